>>> hdl/typed_frame_deframer_xor_check_core_defines.svh
// Assertion helpers used by the deframer control module.
`ifndef TYPED_FRAME_DEFRAMER_XOR_CHECK_CORE_DEFINES_SVH
`define TYPED_FRAME_DEFRAMER_XOR_CHECK_CORE_DEFINES_SVH

// Antecedent true in a cycle requires consequent in the same cycle.
`define TFD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tfd assertion failed");

// Antecedent true in a cycle requires consequent in the following cycle.
`define TFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tfd assertion failed");

`endif

>>> hdl/tfd_pkg.sv
package tfd_pkg;

   localparam int MAX_FRAME = 32;
   localparam int ADDR_W    = $clog2(MAX_FRAME);
   localparam int LEN_W     = 6;
   localparam int BYTE_W    = 8;
   localparam int NUM_SLOTS = 4;
   localparam int CSR_IDX_W = 3;

   // input item kind, carried on req_tuser
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_GAP  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_GOOD    = 2'd0,
      STATUS_UNKNOWN = 2'd1,
      STATUS_BADCHK  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_HUNT,
      S_BODY,
      S_DISCARD,
      S_ERR_TYPE,
      S_ERR_CHECK,
      S_READ,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic load_type;   // type byte taken: store entry 0, latch length
      logic load_body;   // body byte taken: fold into check, store if not check byte
      logic rd_start;    // good frame: rewind read pointer
      logic rd_next;     // byte delivered: advance read pointer
      logic sel_err;     // output byte is the latched type byte
   } ctrl_cmd_type;

   typedef struct packed {
      logic type_hit;    // incoming byte matches an enabled slot
      logic check_byte;  // incoming body byte is the check byte
      logic xor_ok;      // running XOR with incoming byte is zero
      logic rd_last;     // read pointer is on the last output byte
   } dp_status_type;

endpackage

>>> hdl/typed_frame_deframer_xor_check_core.sv
// Channel   Dir  Ports              Content (lowest bit first)
// req       in   req_tdata/tuser    tdata: rx_byte[7:0]; tuser: cmd (1 = line gap)
// rsp       out  rsp_tdata/tuser    tdata: out_byte[7:0]; tuser: status[1:0]; tlast: last
// csr       in   csr_wr_en/index    write-only, 8 register indexes, data 8 bits
//
// One input transaction is taken per cycle while hunting, collecting or discarding.
// A good frame of N bytes (type plus body less check byte) is emitted one byte at a time:
// each byte passes a read state for the registered frame store read, then an emit state.
// An error result is presented in the cycle after the offending byte.
// Input is not taken while a result burst is pending.
// Reset is synchronous, active high; the frame store is not cleared.
// Either side may stall at will; output holds until rsp_tready.
module typed_frame_deframer_xor_check_core (
   input  logic                          clock,
   input  logic                          reset,
   // input stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [tfd_pkg::BYTE_W-1:0]    req_tdata,   // rx_byte
   input  logic                          req_tuser,   // cmd
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [tfd_pkg::BYTE_W-1:0]    rsp_tdata,   // out_byte
   output logic [1:0]                    rsp_tuser,   // status
   output logic                          rsp_tlast,
   // configuration writes
   input  logic                          csr_wr_en,
   input  logic [tfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tfd_pkg::BYTE_W-1:0]    csr_wdata
);
   import tfd_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;
   status_type    rsp_status;
   logic          req_gap;

   assign req_gap = (req_tuser == CMD_GAP);

   // sequencer: frame phase and result burst
   tfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_gap    (req_gap),
      .rsp_tready (rsp_tready),
      .status     (dp_status),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_last   (rsp_tlast),
      .rsp_status (rsp_status),
      .cmd        (cmd)
   );

   // slot table, check accumulator, frame store
   tfd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rx_byte   (req_tdata),
      .cmd       (cmd),
      .status    (dp_status),
      .out_byte  (rsp_tdata)
   );

   assign rsp_tuser = rsp_status;

endmodule

>>> hdl/tfd_datapath.sv
module tfd_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [tfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tfd_pkg::BYTE_W-1:0]  csr_wdata,
   input  logic [tfd_pkg::BYTE_W-1:0]  rx_byte,
   input  tfd_pkg::ctrl_cmd_type       cmd,
   output tfd_pkg::dp_status_type      status,
   output logic [tfd_pkg::BYTE_W-1:0]  out_byte
);
   import tfd_pkg::*;

   logic [BYTE_W-1:0] type_code_ff [NUM_SLOTS];
   logic [LEN_W-1:0]  body_len_ff  [NUM_SLOTS];

   logic [BYTE_W-1:0] frame_store [MAX_FRAME];

   logic [BYTE_W-1:0] type_ff,  type_in;
   logic [BYTE_W-1:0] xor_ff,   xor_in;
   logic [LEN_W-1:0]  exp_ff,   exp_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] rd_idx_ff, rd_idx_in;
   logic [BYTE_W-1:0] rd_data_ff;

   logic [LEN_W-1:0]  lookup_len;
   logic              lookup_hit;
   logic [LEN_W-1:0]  count_next;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;

   // config registers: index bit 0 picks length vs type, upper bits the slot
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            type_code_ff[s] <= '0;
            body_len_ff[s]  <= '0;
         end
      end else if (csr_wr_en) begin
         if (csr_index[0]) begin
            body_len_ff[csr_index[CSR_IDX_W-1:1]] <= csr_wdata[LEN_W-1:0];
         end else begin
            type_code_ff[csr_index[CSR_IDX_W-1:1]] <= csr_wdata;
         end
      end
   end

   // slot lookup, lowest slot wins, length saturated to store depth
   always_comb begin
      lookup_len = '0;
      lookup_hit = 1'b0;
      for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
         if ((body_len_ff[s] != '0) && (type_code_ff[s] == rx_byte)) begin
            lookup_hit = 1'b1;
            lookup_len = (body_len_ff[s] > LEN_W'(MAX_FRAME)) ? LEN_W'(MAX_FRAME)
                                                               : body_len_ff[s];
         end
      end
   end

   assign count_next = count_ff + LEN_W'(1);

   always_comb begin
      type_in   = type_ff;
      xor_in    = xor_ff;
      exp_in    = exp_ff;
      count_in  = count_ff;
      rd_idx_in = rd_idx_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      if (cmd.load_type) begin
         type_in  = rx_byte;
         xor_in   = rx_byte;
         exp_in   = lookup_len;
         count_in = '0;
         wr_en    = 1'b1;
      end
      if (cmd.load_body) begin
         xor_in = xor_ff ^ rx_byte;
         if (!status.check_byte) begin
            wr_en    = 1'b1;
            wr_addr  = count_next[ADDR_W-1:0];
            count_in = count_next;
         end
      end
      if (cmd.rd_start) begin
         rd_idx_in = '0;
      end
      if (cmd.rd_next) begin
         rd_idx_in = rd_idx_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xor_ff    <= '0;
         exp_ff    <= '0;
         count_ff  <= '0;
         rd_idx_ff <= '0;
      end else begin
         xor_ff    <= xor_in;
         exp_ff    <= exp_in;
         count_ff  <= count_in;
         rd_idx_ff <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff <= type_in;
   end

   // frame store, one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_store[wr_addr] <= rx_byte;
      end
      rd_data_ff <= frame_store[rd_idx_ff];
   end

   assign status.type_hit   = lookup_hit;
   assign status.check_byte = (count_next >= exp_ff);
   assign status.xor_ok     = ((xor_ff ^ rx_byte) == '0);
   assign status.rd_last    = (({1'b0, rd_idx_ff} + LEN_W'(1)) == exp_ff);

   assign out_byte = cmd.sel_err ? type_ff : rd_data_ff;

endmodule

>>> hdl/tfd_ctrl.sv
`include "typed_frame_deframer_xor_check_core_defines.svh"

module tfd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_gap,
   input  logic                   rsp_tready,
   input  tfd_pkg::dp_status_type status,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   output logic                   rsp_last,
   output tfd_pkg::status_type    rsp_status,
   output tfd_pkg::ctrl_cmd_type  cmd
);
   import tfd_pkg::*;

   state_type state_ff, state_in;
   logic      req_fire;
   logic      byte_fire;

   assign req_fire  = req_tvalid && req_tready;
   assign byte_fire = req_fire && !req_gap;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_HUNT: begin
            if (byte_fire) state_in = status.type_hit ? S_BODY : S_ERR_TYPE;
         end
         S_BODY: begin
            if (byte_fire && status.check_byte) begin
               state_in = status.xor_ok ? S_READ : S_ERR_CHECK;
            end
         end
         S_DISCARD: begin
            if (req_fire && req_gap) state_in = S_HUNT;
         end
         S_ERR_TYPE, S_ERR_CHECK: begin
            if (rsp_tready) state_in = S_DISCARD;
         end
         S_READ: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_tready) state_in = status.rd_last ? S_HUNT : S_READ;
         end
         default: begin
            state_in = S_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      rsp_last      = 1'b0;
      rsp_status    = STATUS_GOOD;
      cmd           = '0;
      case (state_ff)
         S_HUNT: begin
            req_tready    = 1'b1;
            cmd.load_type = byte_fire;
         end
         S_BODY: begin
            req_tready    = 1'b1;
            cmd.load_body = byte_fire;
            cmd.rd_start  = byte_fire && status.check_byte && status.xor_ok;
         end
         S_DISCARD: begin
            req_tready = 1'b1;
         end
         S_ERR_TYPE: begin
            rsp_tvalid  = 1'b1;
            rsp_last    = 1'b1;
            rsp_status  = STATUS_UNKNOWN;
            cmd.sel_err = 1'b1;
         end
         S_ERR_CHECK: begin
            rsp_tvalid  = 1'b1;
            rsp_last    = 1'b1;
            rsp_status  = STATUS_BADCHK;
            cmd.sel_err = 1'b1;
         end
         S_READ: begin
         end
         S_EMIT: begin
            rsp_tvalid  = 1'b1;
            rsp_last    = status.rd_last;
            cmd.rd_next = rsp_tready && !status.rd_last;
         end
         default: begin
         end
      endcase
   end

   `TFD_ASSERT_IMPLY(a_no_overlap, clock, reset, rsp_tvalid, !req_tready)
   `TFD_ASSERT_IMPLY(a_err_is_last, clock, reset, rsp_tvalid && (rsp_status != STATUS_GOOD), rsp_last)
   `TFD_ASSERT_NEXT(a_start_reads, clock, reset, cmd.rd_start, state_ff == S_READ)
   `TFD_ASSERT_NEXT(a_read_then_emit, clock, reset, state_ff == S_READ, state_ff == S_EMIT)
   `TFD_ASSERT_NEXT(a_err_to_discard, clock, reset, rsp_tvalid && rsp_tready && cmd.sel_err, state_ff == S_DISCARD)

endmodule

>>> tb/typed_frame_deframer_xor_check_core_test.sv
`timescale 1ns / 100ps

module typed_frame_deframer_xor_check_core_test;
   import tfd_pkg::*;

   // Register map: type code and body length per slot, interleaved.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TYPE_CODE_0 = 3'd0,
      REG_BODY_LEN_0  = 3'd1,
      REG_TYPE_CODE_1 = 3'd2,
      REG_BODY_LEN_1  = 3'd3,
      REG_TYPE_CODE_2 = 3'd4,
      REG_BODY_LEN_2  = 3'd5,
      REG_TYPE_CODE_3 = 3'd6,
      REG_BODY_LEN_3  = 3'd7
   } csr_reg_type;

   localparam csr_reg_type TYPE_REG [NUM_SLOTS] =
      '{REG_TYPE_CODE_0, REG_TYPE_CODE_1, REG_TYPE_CODE_2, REG_TYPE_CODE_3};
   localparam csr_reg_type LEN_REG [NUM_SLOTS] =
      '{REG_BODY_LEN_0, REG_BODY_LEN_1, REG_BODY_LEN_2, REG_BODY_LEN_3};

   // Deframer receive state as seen by the predictor.
   typedef enum int {RX_HUNT, RX_BODY, RX_DISCARD} rx_phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      status_type        status;
      logic              last;
   } frame_byte_type;

   localparam int DRAIN_CYCLES = 4 * MAX_FRAME + 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 47;

   // Predicts the output bytes of the deframer and checks them in order.
   class deframe_scoreboard;
      logic [BYTE_W-1:0] type_code [NUM_SLOTS];
      logic [LEN_W-1:0]  body_len [NUM_SLOTS];
      rx_phase_type      phase;
      logic [BYTE_W-1:0] store_copy [MAX_FRAME];
      int unsigned       body_count;
      int unsigned       frame_len;
      logic [BYTE_W-1:0] running_xor;
      frame_byte_type    frame_bytes_q [$];
      int unsigned       fail_count;

      function new();
         foreach (type_code[s]) begin
            type_code[s] = '0;
            body_len[s]  = '0;
         end
         phase       = RX_HUNT;
         body_count  = 0;
         frame_len   = 0;
         running_xor = '0;
         fail_count  = 0;
      endfunction

      function void write_reg(csr_reg_type idx, logic [BYTE_W-1:0] val);
         case (idx)
            REG_TYPE_CODE_0: type_code[0] = val;
            REG_TYPE_CODE_1: type_code[1] = val;
            REG_TYPE_CODE_2: type_code[2] = val;
            REG_TYPE_CODE_3: type_code[3] = val;
            REG_BODY_LEN_0:  body_len[0]  = val[LEN_W-1:0];
            REG_BODY_LEN_1:  body_len[1]  = val[LEN_W-1:0];
            REG_BODY_LEN_2:  body_len[2]  = val[LEN_W-1:0];
            default:         body_len[3]  = val[LEN_W-1:0];
         endcase
      endfunction

      // Effective body length for a type byte; lowest slot wins, 0 = unknown.
      function int unsigned slot_len(logic [BYTE_W-1:0] code);
         for (int s = 0; s < NUM_SLOTS; s++) begin
            if (body_len[s] != 0 && type_code[s] == code)
               return (body_len[s] > MAX_FRAME) ? MAX_FRAME : body_len[s];
         end
         return 0;
      endfunction

      // Returns 1 unless the transaction is one the block just ignores.
      function bit accept_rx(logic cmd, logic [BYTE_W-1:0] data);
         int unsigned len;
         if (cmd == CMD_GAP) begin
            if (phase != RX_DISCARD) return 1'b0;
            phase      = RX_HUNT;
            body_count = 0;
            frame_len  = 0;
            return 1'b1;
         end
         if (phase == RX_DISCARD) return 1'b0;

         if (phase == RX_HUNT) begin
            len           = slot_len(data);
            store_copy[0] = data;
            if (len == 0) begin
               phase      = RX_DISCARD;
               body_count = 0;
               frame_len  = 0;
               frame_bytes_q.push_back('{data, STATUS_UNKNOWN, 1'b1});
               return 1'b1;
            end
            phase       = RX_BODY;
            frame_len   = len;
            body_count  = 0;
            running_xor = data;
            return 1'b1;
         end

         running_xor ^= data;
         if (body_count + 1 < frame_len) begin
            if (body_count + 1 < MAX_FRAME) store_copy[body_count + 1] = data;
            body_count++;
            return 1'b1;
         end

         // check byte
         if (running_xor != 0) begin
            frame_bytes_q.push_back('{store_copy[0], STATUS_BADCHK, 1'b1});
         end else begin
            for (int unsigned i = 0; i < frame_len && i < MAX_FRAME; i++)
               frame_bytes_q.push_back('{store_copy[i], STATUS_GOOD, i + 1 == frame_len});
         end
         phase       = (running_xor != 0) ? RX_DISCARD : RX_HUNT;
         body_count  = 0;
         frame_len   = 0;
         running_xor = '0;
         return 1'b1;
      endfunction

      function void check_rsp(logic [BYTE_W-1:0] data, logic [1:0] stat, logic last);
         frame_byte_type want;
         if (frame_bytes_q.size() == 0) begin
            $error("unexpected result: out_byte %0h status %0d last %0b", data, stat, last);
            fail_count++;
            return;
         end
         want = frame_bytes_q.pop_front();
         if (want.out_byte !== data) begin
            $error("out_byte: expected %0h, actual %0h", want.out_byte, data);
            fail_count++;
         end
         if (want.status !== stat) begin
            $error("status: expected %0d, actual %0d", want.status, stat);
            fail_count++;
         end
         if (want.last !== last) begin
            $error("last: expected %0b, actual %0b", want.last, last);
            fail_count++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [BYTE_W-1:0]    req_tdata;   // rx_byte
   logic                 req_tuser;   // cmd
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [BYTE_W-1:0]    rsp_tdata;   // out_byte
   logic [1:0]           rsp_tuser;   // status
   logic                 rsp_tlast;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_wdata;

   deframe_scoreboard sb = new();

   bit          req_idle_on;   // random gaps before input transactions
   bit          rsp_idle_on;   // random back-pressure on the result side
   int          rsp_stall_left;
   int unsigned live_items;    // transactions that changed the deframer state
   int unsigned cycle_count;

   typed_frame_deframer_xor_check_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // Watchdog: generous bound on the slowest legal run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Result side back-pressure: stall bursts of random length begun at random.
   always @(posedge clock) begin
      if (!rsp_idle_on) begin
         rsp_tready <= 1'b1;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall_left = $urandom_range(1, 10) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result monitor. Values read right after the edge are the pre-edge ones,
   // i.e. the ones the handshake used.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_rsp(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // One input transaction; returns once it has been accepted. The predictor
   // is updated here so that stimulus decisions see the current frame state.
   task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] data);
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (sb.accept_rx(cmd, data)) live_items++;
   endtask

   // Wait for every predicted byte, then for the block to go quiet.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.frame_bytes_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes all eight registers; length writes carry junk in the unused bits.
   task automatic write_config(input logic [BYTE_W-1:0] codes [NUM_SLOTS],
                               input logic [LEN_W-1:0]  lens [NUM_SLOTS]);
      logic [BYTE_W-1:0] val;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         csr_wr_en <= 1'b1;
         csr_index <= TYPE_REG[s];
         csr_wdata <= codes[s];
         sb.write_reg(TYPE_REG[s], codes[s]);
         @(posedge clock);
         val = {2'($urandom_range(0, 3)), lens[s]};
         csr_index <= LEN_REG[s];
         csr_wdata <= val;
         sb.write_reg(LEN_REG[s], val);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_config();
      logic [BYTE_W-1:0] codes [NUM_SLOTS];
      logic [LEN_W-1:0]  lens [NUM_SLOTS];
      int                pick;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         // duplicate codes now and then so slot priority gets exercised
         if (s > 0 && $urandom_range(0, 4) == 0) codes[s] = codes[$urandom_range(0, s - 1)];
         else codes[s] = 8'($urandom_range(0, 255));
         pick = $urandom_range(0, 11);
         if (pick == 0)      lens[s] = '0;
         else if (pick == 1) lens[s] = 6'($urandom_range(MAX_FRAME, 63));
         else if (pick == 2) lens[s] = 6'd1;
         else                lens[s] = 6'($urandom_range(2, 8));
      end
      write_config(codes, lens);
   endtask

   // Bring the deframer back to hunting: finish a frame or end discarding.
   task automatic resync();
      while (sb.phase != RX_HUNT) begin
         if (sb.phase == RX_DISCARD) send_item(CMD_GAP, 8'($urandom_range(0, 255)));
         else send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
      end
   endtask

   // Whole frame for a type byte; the check byte is spoiled when asked.
   task automatic send_frame(input logic [BYTE_W-1:0] code, input bit spoil);
      int unsigned       len;
      logic [BYTE_W-1:0] acc;
      logic [BYTE_W-1:0] body;
      len = sb.slot_len(code);
      send_item(CMD_BYTE, code);
      if (len == 0) return;
      acc = code;
      for (int unsigned i = 1; i < len; i++) begin
         // a line gap inside a frame is ignored
         if ($urandom_range(0, 15) == 0) send_item(CMD_GAP, 8'($urandom_range(0, 255)));
         body = 8'($urandom_range(0, 255));
         acc ^= body;
         send_item(CMD_BYTE, body);
      end
      send_item(CMD_BYTE, spoil ? acc ^ 8'($urandom_range(1, 255)) : acc);
   endtask

   function automatic logic [BYTE_W-1:0] unknown_code();
      logic [BYTE_W-1:0] code;
      do code = 8'($urandom_range(0, 255)); while (sb.slot_len(code) != 0);
      return code;
   endfunction

   task automatic random_phase(input int unsigned target);
      int unsigned start;
      int          act;
      int          live_slots [$];
      start = live_items;
      while (live_items - start < target) begin
         resync();
         live_slots.delete();
         for (int s = 0; s < NUM_SLOTS; s++)
            if (sb.body_len[s] != 0) live_slots.push_back(s);
         act = $urandom_range(0, 99);
         if (act < 78 && live_slots.size() != 0) begin
            // mostly well formed frames, some with a bad check byte
            send_frame(sb.type_code[live_slots[$urandom_range(0, live_slots.size() - 1)]],
                       act >= 64);
         end else if (act < 90) begin
            // unknown type, then junk that the block must drop
            send_item(CMD_BYTE, unknown_code());
            repeat ($urandom_range(0, 3)) send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
         end else begin
            send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      logic [BYTE_W-1:0] codes [NUM_SLOTS];
      logic [LEN_W-1:0]  lens [NUM_SLOTS];

      reset          <= 1'b1;
      req_tvalid     <= 1'b0;
      req_tdata      <= '0;
      req_tuser      <= CMD_BYTE;
      rsp_tready     <= 1'b0;
      csr_wr_en      <= 1'b0;
      csr_index      <= REG_TYPE_CODE_0;
      csr_wdata      <= '0;
      req_idle_on    = 1'b1;
      rsp_idle_on    = 1'b1;
      rsp_stall_left = 0;
      live_items     = 0;
      cycle_count    = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset config: every slot off, so even type 0 is unknown.
      send_item(CMD_BYTE, 8'h00);
      send_item(CMD_BYTE, 8'hFF);   // dropped while discarding
      send_item(CMD_GAP,  8'h5A);   // back to hunting
      drain();

      // Length one, duplicate code (slot one wins), length above the store.
      codes = '{8'hA5, 8'h3C, 8'h3C, 8'hFF};
      lens  = '{6'd1, 6'd4, 6'd7, 6'd63};
      write_config(codes, lens);
      send_item(CMD_GAP,  8'hFF);   // gap while hunting: ignored
      send_item(CMD_BYTE, 8'hA5);   // length one, good
      send_item(CMD_BYTE, 8'hA5);
      send_item(CMD_BYTE, 8'hA5);   // length one, bad check
      send_item(CMD_BYTE, 8'h00);
      send_item(CMD_BYTE, 8'h00);   // dropped
      send_item(CMD_GAP,  8'h00);
      send_item(CMD_BYTE, 8'h3C);   // four byte body, lowest slot decides
      send_item(CMD_BYTE, 8'h00);
      send_item(CMD_GAP,  8'h00);   // gap mid-frame: ignored
      send_item(CMD_BYTE, 8'hFF);
      send_item(CMD_BYTE, 8'h81);
      send_item(CMD_BYTE, 8'h42);
      send_item(CMD_BYTE, 8'h7E);   // unknown type
      send_item(CMD_GAP,  8'h7E);
      send_item(CMD_BYTE, 8'h3C);   // frame left open across a config change
      send_item(CMD_BYTE, 8'h12);
      drain();

      // Extremes; the open frame keeps the length it started with.
      codes = '{8'h00, 8'h3C, 8'h80, 8'hFF};
      lens  = '{6'd33, 6'd2, 6'd32, 6'd1};
      write_config(codes, lens);
      send_item(CMD_BYTE, 8'h34);
      send_item(CMD_BYTE, 8'h56);
      send_item(CMD_BYTE, 8'h4C);
      random_phase(PHASE_ITEMS);

      for (int p = 0; p < 5; p++) begin
         drain();
         random_config();
         req_idle_on = (p != 4) && (p != 2);
         rsp_idle_on = (p != 4) && (p != 1);
         random_phase(PHASE_ITEMS);
      end

      drain();
      if (sb.frame_bytes_q.size() != 0) begin
         $error("%0d expected results never arrived", sb.frame_bytes_q.size());
         sb.fail_count++;
      end
      if (sb.fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/tfd_pkg.sv
hdl/tfd_datapath.sv
hdl/tfd_ctrl.sv
hdl/typed_frame_deframer_xor_check_core.sv
tb/typed_frame_deframer_xor_check_core_test.sv
